### hdl/tcgw_pkg.sv
`default_nettype none
package tcgw_pkg;

	localparam int TEXT_COLUMNS = 21;
	localparam int TEXT_ROWS = 8;

	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LAST_PRINT = 8'h7F;
	localparam logic [6:0] GLYPH_SPACE = 7'd0;

	typedef enum logic [1:0] {
		CUR_HOLD = 2'd0,
		CUR_ADV = 2'd1,
		CUR_NL = 2'd2,
		CUR_CR = 2'd3
	} cur_op_t;

	typedef struct packed {
		logic [4:0] col;
		logic [2:0] row;
		logic on_stop;
		logic next_on_stop;
		logic in_range;
		logic hits_end;
	} cur_stat_t;

endpackage
`default_nettype wire

### hdl/tcgw_cursor.sv
`default_nettype none
module tcgw_cursor (
	input wire logic clk,
	input wire logic arst_n,
	input wire tcgw_pkg::cur_op_t op,
	output tcgw_pkg::cur_stat_t stat
);
	import tcgw_pkg::*;

	logic [4:0] col_q;
	logic [2:0] row_q;
	logic [5:0] col_p1;
	logic [3:0] row_p1;
	logic [2:0] row_next;
	logic hits_end;

	always_comb begin
		col_p1 = {1'b0, col_q} + 6'd1;
		hits_end = col_p1 >= 6'(TEXT_COLUMNS);
		row_p1 = {1'b0, row_q} + 4'd1;
		row_next = (row_p1 == 4'(TEXT_ROWS)) ? 3'd0 : row_p1[2:0];
		stat.col = col_q;
		stat.row = row_q;
		stat.on_stop = col_q[2:0] == 3'd0;
		stat.next_on_stop = col_p1[2:0] == 3'd0;
		stat.in_range = {1'b0, col_q} < 6'(TEXT_COLUMNS);
		stat.hits_end = hits_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 5'd0;
			row_q <= 3'd0;
		end else begin
			case (op)
				CUR_ADV: begin
					if (hits_end) begin
						col_q <= 5'd0;
						row_q <= row_next;
					end else begin
						col_q <= col_p1[4:0];
					end
				end
				CUR_NL: begin
					col_q <= 5'd0;
					row_q <= row_next;
				end
				CUR_CR: begin
					col_q <= 5'd0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/tcgw_seq.sv
`default_nettype none
module tcgw_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_byte,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [6:0] m_glyph,
	output logic [4:0] m_col,
	output logic [2:0] m_row,
	output logic m_last,
	input wire tcgw_pkg::cur_stat_t stat,
	output tcgw_pkg::cur_op_t op
);
	import tcgw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_OUT = 3'b010,
		S_TAB = 3'b100
	} state_t;

	state_t state_q;
	logic m_valid_q;
	logic [6:0] glyph_q;
	logic [4:0] col_q;
	logic [2:0] row_q;
	logic last_q;
	logic accept;
	logic tab_emit;
	logic tab_last;
	logic [6:0] glyph_full;

	assign s_tready = state_q == S_IDLE;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_glyph = glyph_q;
	assign m_col = col_q;
	assign m_row = row_q;
	assign m_last = last_q;
	assign tab_emit = !stat.on_stop && stat.in_range;
	assign tab_last = stat.next_on_stop || stat.hits_end;
	assign glyph_full = s_byte[6:0] - CHAR_SPACE[6:0];

	always_comb begin
		op = CUR_HOLD;
		if (accept && s_byte == CHAR_LF) begin
			op = CUR_NL;
		end else if (accept && s_byte == CHAR_CR) begin
			op = CUR_CR;
		end else if (state_q == S_OUT && m_tready) begin
			op = CUR_ADV;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= stat.col;
			row_q <= stat.row;
			if (s_byte == CHAR_TAB) begin
				glyph_q <= GLYPH_SPACE;
				last_q <= tab_last;
			end else if (s_byte inside {[CHAR_SPACE:CHAR_LAST_PRINT]}) begin
				glyph_q <= glyph_full;
				last_q <= 1'b1;
			end else begin
				glyph_q <= GLYPH_SPACE;
				last_q <= 1'b1;
			end
		end else if (state_q == S_TAB) begin
			col_q <= stat.col;
			row_q <= stat.row;
			glyph_q <= GLYPH_SPACE;
			last_q <= tab_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_byte == CHAR_TAB) begin
							if (tab_emit) begin
								m_valid_q <= 1'b1;
								state_q <= S_OUT;
							end
						end else if (s_byte != CHAR_LF && s_byte != CHAR_CR) begin
							m_valid_q <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						state_q <= last_q ? S_IDLE : S_TAB;
					end
				end
				S_TAB: begin
					m_valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				default: begin
					m_valid_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/text_cursor_glyph_writer_core.sv
// A printable or other glyph-writing byte shows its registered item in the cycle after acceptance.
// A new byte is accepted only while idle, after the last item is taken; newline and carriage
// return write no item. A tab writes up to seven spaces, one per item, passing through a tab
// state between spaces because the single cursor incrementer is reused for each space.
// Reset: arst_n clears the cursor to column 0, row 0 and empties the output register.
`default_nettype none
module text_cursor_glyph_writer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // char_byte
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata, // glyph_index, text_column, text_row, zero pad
	output logic m_tlast
);
	import tcgw_pkg::*;

	cur_stat_t stat;
	cur_op_t op;
	logic [6:0] glyph;
	logic [4:0] col;
	logic [2:0] row;

	tcgw_cursor u_cursor (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.stat(stat)
	);

	tcgw_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_byte(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_glyph(glyph),
		.m_col(col),
		.m_row(row),
		.m_last(m_tlast),
		.stat(stat),
		.op(op)
	);

	assign m_tdata = {1'b0, row, col, glyph};

endmodule
`default_nettype wire

### test/tcgw_glyph_checker.sv
`timescale 1ns / 100ps
module tcgw_glyph_checker
	import tcgw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [7:0] s_tdata, // char_byte
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [15:0] m_tdata, // glyph_index, text_column, text_row, zero pad
	input wire logic m_tlast,
	output int fail_count,
	output int pending,
	output int writes_checked
);

	typedef struct packed {
		logic [6:0] glyph;
		logic [4:0] col;
		logic [2:0] row;
		logic last;
	} glyph_write_t;

	glyph_write_t glyph_writes_due[$];
	logic [4:0] cursor_col;
	logic [2:0] cursor_row;

	task automatic queue_write(input logic [6:0] glyph, input logic last);
		glyph_write_t w;
		w.glyph = glyph;
		w.col = cursor_col;
		w.row = cursor_row;
		w.last = last;
		glyph_writes_due.push_back(w);
	endtask

	task automatic next_row();
		cursor_row = 3'((int'(cursor_row) + 1) % TEXT_ROWS);
		cursor_col = 5'd0;
	endtask

	task automatic predict_writes(input logic [7:0] b);
		logic [6:0] glyph;
		case (b)
			CHAR_TAB: begin
				// The final space is the one that lands the cursor on a tab stop or the edge.
				while (cursor_col[2:0] != 3'd0 && int'(cursor_col) < TEXT_COLUMNS) begin
					queue_write(GLYPH_SPACE,
						cursor_col[2:0] == 3'd7 || int'(cursor_col) + 1 >= TEXT_COLUMNS);
					cursor_col = cursor_col + 5'd1;
				end
				if (int'(cursor_col) >= TEXT_COLUMNS) next_row();
			end
			CHAR_LF: next_row();
			CHAR_CR: cursor_col = 5'd0;
			default: begin
				if (b < CHAR_SPACE || b > CHAR_LAST_PRINT) glyph = GLYPH_SPACE;
				else glyph = 7'(b - CHAR_SPACE);
				queue_write(glyph, 1'b1);
				cursor_col = cursor_col + 5'd1;
				if (int'(cursor_col) >= TEXT_COLUMNS) next_row();
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		glyph_write_t want;
		if (!arst_n) begin
			glyph_writes_due.delete();
			cursor_col = 5'd0;
			cursor_row = 3'd0;
			fail_count <= 0;
			pending <= 0;
			writes_checked <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (glyph_writes_due.size() == 0) begin
					$display("%0t: unexpected glyph write: got glyph %0d col %0d row %0d last %0d",
						$time, m_tdata[6:0], m_tdata[11:7], m_tdata[14:12], m_tlast);
					fail_count <= fail_count + 1;
				end else begin
					want = glyph_writes_due.pop_front();
					writes_checked <= writes_checked + 1;
					if (m_tdata[6:0] !== want.glyph || m_tdata[11:7] !== want.col ||
							m_tdata[14:12] !== want.row || m_tlast !== want.last ||
							m_tdata[15] !== 1'b0) begin
						$display("%0t: glyph write mismatch: expected glyph %0d col %0d row %0d last %0d pad 0, got glyph %0d col %0d row %0d last %0d pad %0d",
							$time, want.glyph, want.col, want.row, want.last,
							m_tdata[6:0], m_tdata[11:7], m_tdata[14:12], m_tlast, m_tdata[15]);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) predict_writes(s_tdata);
			pending <= glyph_writes_due.size();
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import tcgw_pkg::*;

	localparam int IDLE_LIMIT = 500;
	localparam int RANDOM_ITEMS = 230;
	localparam logic [7:0] DIRECTED_BYTES [0:23] = '{
		CHAR_TAB, 8'h41, CHAR_TAB, CHAR_TAB, 8'hFF, CHAR_TAB, 8'h00, CHAR_TAB,
		CHAR_LF, CHAR_SPACE, 8'h7E, CHAR_LAST_PRINT, 8'h80, 8'h1F, CHAR_CR, 8'h01,
		8'h0C, 8'h0E, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic m_tlast;

	int fail_count;
	int pending;
	int writes_checked;
	int bytes_sent = 0;
	int tabs_sent = 0;
	int line_ctl_sent = 0;
	int rx_wait = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	text_cursor_glyph_writer_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	tcgw_glyph_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending(pending),
		.writes_checked(writes_checked)
	);

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			rx_wait = no_idle ? 0 : $urandom_range(0, 5);
			m_tready <= (rx_wait == 0);
		end else if (rx_wait > 0) begin
			rx_wait = rx_wait - 1;
			m_tready <= (rx_wait == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
			$display("** text_cursor_glyph_writer_core: FAILED **");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		if (b == CHAR_TAB) tabs_sent++;
		if (b == CHAR_LF || b == CHAR_CR) line_ctl_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int r;
		logic [7:0] b;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2) wait_drained();
			r = $urandom_range(0, 99);
			if (r < 55) b = 8'($urandom_range(32'h20, 32'h7E));
			else if (r < 70) b = CHAR_TAB;
			else if (r < 78) b = CHAR_LF;
			else if (r < 84) b = CHAR_CR;
			else b = 8'($urandom_range(0, 255));
			send_byte(b);
		end

		no_idle = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Run covered %0d bytes (%0d tabs, %0d newlines or carriage returns)",
			bytes_sent, tabs_sent, line_ctl_sent);
		$display("and checked %0d glyph writes; %0d still outstanding.", writes_checked, pending);
		if (fail_count == 0 && pending == 0) begin
			$display("** text_cursor_glyph_writer_core: PASSED **");
		end else begin
			$display("** text_cursor_glyph_writer_core: FAILED **");
		end
		$finish;
	end

endmodule
